### rtl/acl_prefix_table_binary_search_unit_defines.svh
// Assertion macros shared by the access-list lookup block.
`ifndef ACL_PREFIX_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define ACL_PREFIX_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ACL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ACL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ACL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/aclbs_pkg.sv
// Package of types and constants for the access-list lookup block.
package aclbs_pkg;
    localparam int TableDepth = 256;
    localparam int KeyBytes = 16;
    localparam int CountW = 9;
    localparam logic [CountW-1:0] CountReset = 9'd1;
    localparam logic CmdWrite = 1'b0;
    localparam logic CmdLookup = 1'b1;
    localparam int InDataW = 168;
    localparam int OutDataW = 24;
endpackage

### rtl/acl_prefix_table_binary_search_unit.sv
// Access-list lookup: a pipelined binary search over a sorted prefix table.
// Throughput: one item per cycle while the output side is not stalled.
// Each search level reads its own table copy in one stage and compares in the next;
// a write travels down the same stages, updates each copy as it passes and has no result.
// Reset (synchronous, active low) clears valid bits and sets r_count to 1, not the tables.
`include "acl_prefix_table_binary_search_unit_defines.svh"
module acl_prefix_table_binary_search_unit #(
    parameter int TABLE_DEPTH = aclbs_pkg::TableDepth,
    parameter int KEY_BYTES = aclbs_pkg::KeyBytes
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [aclbs_pkg::CountW-1:0] i_cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // entry_index, entry_verdict, entry_prefix_bytes, entry_last_mask, family, key_high, key_low
    input  logic [aclbs_pkg::InDataW-1:0] s_axis_tdata,
    input  logic s_axis_tuser, // cmd
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // matched, verdict, matched_index, then seven zero bits
    output logic [aclbs_pkg::OutDataW-1:0] m_axis_tdata
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LIMW = AW + 1;
    localparam int LV = AW + 1;
    localparam int NS = 2 * LV;
    localparam int EW = 29 + 128;

    typedef struct packed {
        logic       vld;
        logic       cmd;
        logic       wr;
        logic [AW-1:0] widx;
        logic [4:0] pb;
        logic [7:0] msk;
        logic [7:0] fam;
        logic [127:0] key;
        logic [LIMW-1:0] base;
        logic [LIMW-1:0] lim;
        logic       hit;
        logic [7:0] verd;
        logic [LIMW-1:0] idx;
    } t_stage;

    logic r_cfg_ok;
    logic [aclbs_pkg::CountW-1:0] r_count;
    t_stage r_st [NS+1];
    t_stage n_st0;
    logic [EW-1:0] r_rd [LV];
    logic [EW-1:0] r_mem [LV][TABLE_DEPTH];
    logic r_ovld;
    logic [aclbs_pkg::OutDataW-1:0] r_odata;
    logic adv;
    logic [7:0] in_idx;
    logic [LIMW-1:0] lim0;

    assign adv = !r_ovld || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_idx = s_axis_tdata[7:0];

    always_comb begin
        if (32'(r_count) > 32'(TABLE_DEPTH)) begin
            lim0 = LIMW'(TABLE_DEPTH);
        end else begin
            lim0 = LIMW'(r_count);
        end
        n_st0 = '0;
        n_st0.vld = s_axis_tvalid;
        n_st0.cmd = s_axis_tuser;
        n_st0.wr = (s_axis_tuser == aclbs_pkg::CmdWrite) && (32'(in_idx) < 32'(TABLE_DEPTH));
        n_st0.widx = AW'(in_idx);
        n_st0.verd = s_axis_tdata[15:8];
        n_st0.pb = s_axis_tdata[20:16];
        n_st0.msk = s_axis_tdata[28:21];
        n_st0.fam = s_axis_tdata[36:29];
        n_st0.key = {s_axis_tdata[100:37], s_axis_tdata[164:101]};
        n_st0.lim = lim0;
    end

    function automatic logic signed [1:0] cmp_entry(input logic [7:0] fam,
            input logic [127:0] key, input logic [EW-1:0] e);
        logic [7:0] efam;
        logic [4:0] pb;
        logic [7:0] msk;
        logic [127:0] ek;
        logic [7:0] a;
        logic [7:0] b;
        logic signed [1:0] res;
        logic done;
        efam = e[156:149];
        msk = e[148:141];
        pb = e[140:136];
        ek = e[127:0];
        res = 2'sd0;
        done = 1'b0;
        if (pb > 5'(KEY_BYTES)) pb = 5'(KEY_BYTES);
        if (fam != efam) begin
            res = (fam < efam) ? -2'sd1 : 2'sd1;
            done = 1'b1;
        end
        for (int i = 0; i < KEY_BYTES; i++) begin
            a = key[127-8*i -: 8];
            b = ek[127-8*i -: 8];
            if (!done && 5'(i) < pb && a != b) begin
                res = (a < b) ? -2'sd1 : 2'sd1;
                done = 1'b1;
            end
            if (!done && 5'(i) == pb && msk != 8'd0 && (a & msk) != b) begin
                res = ((a & msk) < b) ? -2'sd1 : 2'sd1;
                done = 1'b1;
            end
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= aclbs_pkg::CountReset;
            r_cfg_ok <= 1'b0;
        end else begin
            r_cfg_ok <= 1'b1;
            if (i_cfg_we) r_count <= i_cfg_wdata;
        end
    end

    for (genvar l = 0; l < LV; l++) begin : g_lvl
        logic [LIMW-1:0] mid;
        logic signed [1:0] c;
        logic active;
        t_stage n_rd;
        t_stage n_cmp;
        assign mid = r_st[2*l].base + (r_st[2*l].lim >> 1);
        assign c = cmp_entry(r_st[2*l+1].fam, r_st[2*l+1].key, r_rd[l]);
        assign active = r_st[2*l+1].cmd && !r_st[2*l+1].hit && (r_st[2*l+1].lim != '0);
        always_comb begin
            n_rd = r_st[2*l];
            n_rd.idx = mid;
            n_cmp = r_st[2*l+1];
            if (active) begin
                if (c == 2'sd0) begin
                    n_cmp.hit = 1'b1;
                    n_cmp.verd = r_rd[l][135:128];
                end else if (c > 2'sd0) begin
                    n_cmp.base = r_st[2*l+1].idx + LIMW'(1);
                    n_cmp.lim = (r_st[2*l+1].lim - LIMW'(1)) >> 1;
                end else begin
                    n_cmp.lim = r_st[2*l+1].lim >> 1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv && r_st[2*l].vld && r_st[2*l].wr) begin
                r_mem[l][r_st[2*l].widx] <= {r_st[2*l].fam, r_st[2*l].msk, r_st[2*l].pb,
                                             r_st[2*l].verd, r_st[2*l].key};
            end
            if (adv) r_rd[l] <= r_mem[l][mid[AW-1:0]];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[2*l+1].vld <= 1'b0;
                r_st[2*l+2].vld <= 1'b0;
            end else if (adv) begin
                r_st[2*l+1] <= n_rd;
                r_st[2*l+2] <= n_cmp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].vld <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (adv) r_st[0] <= n_st0;
            if (adv) begin
                r_ovld <= r_st[NS].vld && r_st[NS].cmd;
                r_odata <= {7'd0, r_st[NS].hit ? 8'(r_st[NS].idx) : 8'd0,
                            r_st[NS].hit ? r_st[NS].verd : 8'd0, r_st[NS].hit};
            end
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = r_odata;

    `ACL_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ovld && !m_axis_tready, r_ovld && $stable(r_odata), "held result changed")
    `ACL_ASSERT_IMP(a_ready, i_clk, i_rst_n, !r_ovld, s_axis_tready, "not ready with empty output")
    `ACL_ASSERT_IMP(a_miss, i_clk, i_rst_n, r_ovld && !r_odata[0], r_odata[16:1] == 16'd0, "miss with nonzero payload")
    `ACL_ASSERT_IMP(a_cfg, i_clk, i_rst_n, r_cfg_ok, r_count <= 9'd511, "count out of range")
endmodule

### tb/sv/acl_lookup_checker.sv
// Checker for the access-list lookup block: predicts lookup results and compares them.
module acl_lookup_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [aclbs_pkg::CountW-1:0] i_cfg_wdata,
    input  logic i_s_tvalid,
    input  logic i_s_tready,
    input  logic [aclbs_pkg::InDataW-1:0] i_s_tdata,
    input  logic i_s_tuser,
    input  logic i_m_tvalid,
    input  logic i_m_tready,
    input  logic [aclbs_pkg::OutDataW-1:0] i_m_tdata,
    output int o_errors,
    output int o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       matched;
        logic [7:0] verdict;
        logic [7:0] index;
    } t_lookup_result;

    logic [7:0]   rule_verdict [aclbs_pkg::TableDepth];
    logic [4:0]   rule_prefix [aclbs_pkg::TableDepth];
    logic [7:0]   rule_mask [aclbs_pkg::TableDepth];
    logic [7:0]   rule_family [aclbs_pkg::TableDepth];
    logic [127:0] rule_key [aclbs_pkg::TableDepth];
    logic [aclbs_pkg::CountW-1:0] searched_count;
    t_lookup_result expected_verdicts[$];

    function automatic logic [7:0] byte_of(logic [127:0] k, int i);
        return k[127-8*i -: 8];
    endfunction

    // Sign of the address relative to the entry in the given slot.
    function automatic int order_against(logic [7:0] fam, logic [127:0] addr, int slot);
        int pb;
        logic [7:0] a, b;
        if (fam != rule_family[slot]) return (fam < rule_family[slot]) ? -1 : 1;
        pb = (rule_prefix[slot] > aclbs_pkg::KeyBytes) ? aclbs_pkg::KeyBytes : rule_prefix[slot];
        for (int i = 0; i < pb; i++) begin
            a = byte_of(addr, i);
            b = byte_of(rule_key[slot], i);
            if (a != b) return (a < b) ? -1 : 1;
        end
        if (rule_mask[slot] != 0 && pb < aclbs_pkg::KeyBytes) begin
            a = byte_of(addr, pb) & rule_mask[slot];
            b = byte_of(rule_key[slot], pb);
            if (a != b) return (a < b) ? -1 : 1;
        end
        return 0;
    endfunction

    function automatic t_lookup_result search_table(logic [7:0] fam, logic [127:0] addr);
        t_lookup_result r;
        int lim, base, mid, c;
        r = '0;
        lim = (searched_count > aclbs_pkg::TableDepth) ? aclbs_pkg::TableDepth : searched_count;
        base = 0;
        while (lim != 0) begin
            mid = base + (lim >> 1);
            if (mid >= aclbs_pkg::TableDepth) break;
            c = order_against(fam, addr, mid);
            if (c == 0) begin
                r.matched = 1'b1;
                r.verdict = rule_verdict[mid];
                r.index = mid[7:0];
                break;
            end
            if (c > 0) begin
                base = mid + 1;
                lim--;
            end
            lim = lim >> 1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_result want, got;
        int slot;
        if (!i_rst_n) begin
            searched_count = aclbs_pkg::CountReset;
            expected_verdicts.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) searched_count = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) begin
                got = '0;
                got.matched = i_m_tdata[0];
                got.verdict = i_m_tdata[8:1];
                got.index = i_m_tdata[16:9];
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result matched=%0d verdict=%0d index=%0d",
                             $time, got.matched, got.verdict, got.index);
                    o_errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected matched=%0d verdict=%0d index=%0d, got %0d %0d %0d",
                                 $time, want.matched, want.verdict, want.index,
                                 got.matched, got.verdict, got.index);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == aclbs_pkg::CmdWrite) begin
                    slot = i_s_tdata[7:0];
                    rule_verdict[slot] = i_s_tdata[15:8];
                    rule_prefix[slot] = i_s_tdata[20:16];
                    rule_mask[slot] = i_s_tdata[28:21];
                    rule_family[slot] = i_s_tdata[36:29];
                    rule_key[slot] = {i_s_tdata[100:37], i_s_tdata[164:101]};
                end else begin
                    expected_verdicts.push_back(
                        search_table(i_s_tdata[36:29], {i_s_tdata[100:37], i_s_tdata[164:101]}));
                end
            end
        end
        o_pending = expected_verdicts.size();
    end
endmodule

### tb/sv/testbench.sv
// Top of the access-list lookup testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 19;
    localparam int CycleLimit = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [aclbs_pkg::CountW-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [aclbs_pkg::InDataW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = aclbs_pkg::CmdWrite;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [aclbs_pkg::OutDataW-1:0] m_axis_tdata;
    int errors, pending, cycles;
    bit sender_calm = 1'b0;
    bit receiver_calm = 1'b0;

    logic [7:0]   slot_family [aclbs_pkg::TableDepth];
    logic [4:0]   slot_prefix [aclbs_pkg::TableDepth];
    logic [127:0] slot_key [aclbs_pkg::TableDepth];

    always #6 i_clk = ~i_clk;

    acl_prefix_table_binary_search_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    acl_lookup_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_s_tuser(s_axis_tuser), .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver stalls in bursts until the calm part of the run.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!receiver_calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(logic cmd, logic [aclbs_pkg::InDataW-1:0] data);
        int n;
        if (!sender_calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_slot(int slot, logic [7:0] verdict, logic [4:0] pb, logic [7:0] mask,
                              logic [7:0] fam, logic [127:0] key);
        slot_family[slot] = fam;
        slot_prefix[slot] = pb;
        slot_key[slot] = key;
        send_item(aclbs_pkg::CmdWrite,
                  {3'b0, key[63:0], key[127:64], fam, mask, pb, verdict, slot[7:0]});
    endtask

    // Entries are sorted by family (four bands) and then by a unique leading byte.
    task automatic load_sorted_slot(int slot);
        logic [127:0] key;
        logic [4:0] pb;
        logic [7:0] mask;
        key = {$urandom, $urandom, $urandom, $urandom};
        key[127:120] = 8'((slot % 64) * 4 + $urandom_range(0, 3));
        pb = 5'($urandom_range(1, 16));
        mask = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
        if (pb < 16 && mask != 0 && $urandom_range(0, 1)) key[127-8*pb -: 8] &= mask;
        write_slot(slot, 8'($urandom), pb, mask, 8'((slot / 64) * 85), key);
    endtask

    task automatic look_up(logic [7:0] fam, logic [127:0] addr);
        send_item(aclbs_pkg::CmdLookup, {3'b0, addr[63:0], addr[127:64], fam, 29'($urandom)});
    endtask

    // Mostly addresses that fall under a stored entry, with random bytes beyond the prefix.
    task automatic look_up_near(int slot);
        logic [127:0] addr;
        int pb;
        addr = {$urandom, $urandom, $urandom, $urandom};
        pb = (slot_prefix[slot] > 16) ? 16 : slot_prefix[slot];
        for (int i = 0; i < pb; i++) addr[127-8*i -: 8] = slot_key[slot][127-8*i -: 8];
        if (pb < 16 && $urandom_range(0, 3) != 0)
            addr[127-8*pb -: 8] = slot_key[slot][127-8*pb -: 8];
        if ($urandom_range(0, 9) == 0) look_up(8'($urandom), addr);
        else look_up(slot_family[slot], addr);
    endtask

    task automatic quiet_set_count(logic [aclbs_pkg::CountW-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (Latency + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [aclbs_pkg::CountW-1:0] counts [6];
        int slot;
        counts = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd255, 9'd100};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < aclbs_pkg::TableDepth; i++) load_sorted_slot(i);

        // Directed: whole-key prefix with a mask that must be ignored, prefix of zero,
        // a stored partial byte with bits outside the mask, family extremes.
        write_slot(0, 8'hff, 5'd16, 8'hf0, 8'h00, {128{1'b1}});
        write_slot(255, 8'h5a, 5'd0, 8'h00, 8'hff, '0);
        write_slot(64, 8'h01, 5'd2, 8'h0f, 8'd85, {8'h00, 8'h00, 8'hff, 104'h0});
        quiet_set_count(9'd256);
        look_up(8'h00, {128{1'b1}});
        look_up(8'hff, {$urandom, $urandom, $urandom, $urandom});
        look_up(8'd85, {8'h00, 8'h00, 8'hff, 104'h0});
        look_up(8'd85, {8'h00, 8'h00, 8'h0f, 104'h0});
        look_up(8'h7f, '0);
        for (int i = 0; i < 6; i++) look_up_near($urandom_range(0, 255));
        quiet_set_count(9'd0);
        look_up(8'h00, {128{1'b1}});
        look_up_near(128);
        quiet_set_count(9'd511);
        look_up(8'hff, '0);
        look_up_near(200);
        for (int i = 0; i < aclbs_pkg::TableDepth; i++) load_sorted_slot(i);

        foreach (counts[p]) begin
            quiet_set_count(counts[p]);
            if (p == 5) begin
                sender_calm = 1'b1;
                receiver_calm = 1'b1;
            end
            repeat (187) begin
                slot = $urandom_range(0, 255);
                if ($urandom_range(0, 9) == 0) load_sorted_slot(slot);
                else if ($urandom_range(0, 19) == 0)
                    look_up(8'($urandom), {$urandom, $urandom, $urandom, $urandom});
                else look_up_near(slot);
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (Latency + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
